FILE: rtl/ssi_pkg.sv
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared types and constants for the segment/segment intersection pipeline.
// ----------------------------------------------------------------------------
package ssi_pkg;

    localparam int COORD_BITS    = 16;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DIFF_W        = COORD_BITS + 1;
    localparam int OUT_W         = 32;

    localparam logic [1:0] CLS_NONE    = 2'd0;
    localparam logic [1:0] CLS_PROPER  = 2'd1;
    localparam logic [1:0] CLS_VERTEX  = 2'd2;
    localparam logic [1:0] CLS_OVERLAP = 2'd3;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by_coord;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [COORD_BITS-1:0] dx;
        logic signed [COORD_BITS-1:0] dy;
    } ssi_in_t;

    typedef struct packed {
        logic [1:0]              hit_class;
        logic signed [OUT_W-1:0] px;
        logic signed [OUT_W-1:0] py;
    } ssi_out_t;

    // sideband carried alongside the divider
    typedef struct packed {
        logic [1:0]                   cls;
        logic                         par;
        logic signed [OUT_W-1:0]      ppx;
        logic signed [OUT_W-1:0]      ppy;
        logic                         neg_s;
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [DIFF_W-1:0]     ex;
        logic signed [DIFF_W-1:0]     ey;
    } ssi_side_t;

endpackage

FILE: rtl/segment_segment_intersect.sv
// ----------------------------------------------------------------------------
// segment_segment_intersect
// Classifies how segments AB and CD meet and returns the meeting point in
// signed fixed point with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one segment pair (ssi_in_t) per transaction.
//   m_valid/m_ready/m_data return one result (ssi_out_t) per transaction:
//   hit_class and the point px, py.
//   Throughput: one transaction per cycle, sustained while the output is not stalled.
//   Pipeline: two cross-product stages, the bit-per-stage divider of
//   s = ns/den with one stage per quotient bit, three stages for saturation
//   and the point multiply, and the output register.
//   Stall: the whole pipeline holds while m_valid is high and m_ready low;
//   s_ready drops in the same cycle, nothing is dropped or repeated.
//   Reset: aresetn (synchronous, active low) clears all valid bits; items in
//   flight are discarded and m_valid goes low.
// ----------------------------------------------------------------------------
module segment_segment_intersect
    import ssi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ssi_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ssi_out_t m_data
);

    localparam int C      = COORD_BITS;
    localparam int PW     = 2 * C + 2;
    localparam int SW     = 2 * C + 3;
    localparam int MAGW   = 2 * C + 2;
    localparam int QB     = MAGW + FRAC_BITS;
    localparam int CK     = ((C + FRAC_BITS > 32) ? C + FRAC_BITS : 32) + 1;
    localparam int QC     = CK + 1;
    localparam int QX     = (QB > QC) ? QB : QC;
    localparam int QL     = (QC + 1) / 2;
    localparam int QH     = QC - QL;
    localparam int PLW    = QL + DIFF_W;
    localparam int PHW    = QH + DIFF_W;
    localparam int MGW    = QC + DIFF_W;
    localparam int MW     = MGW + 1;
    localparam int RW     = MW + 1;
    localparam int FW     = (C + FRAC_BITS + 1 > 33) ? C + FRAC_BITS + 1 : 33;
    localparam int SIDE_W = $bits(ssi_side_t);

    localparam logic signed [FW-1:0] FIX_MAX = (FW'(1) <<< 31) - FW'(1);
    localparam logic signed [FW-1:0] FIX_MIN = -(FW'(1) <<< 31);
    localparam logic signed [RW-1:0] RES_MAX = (RW'(1) <<< 31) - RW'(1);
    localparam logic signed [RW-1:0] RES_MIN = -(RW'(1) <<< 31);
    localparam logic [QX-1:0]        Q_CAP   = QX'(1) << CK;

    function automatic logic between(
        input logic signed [C-1:0] x0, input logic signed [C-1:0] y0,
        input logic signed [C-1:0] x1, input logic signed [C-1:0] y1,
        input logic signed [C-1:0] qx, input logic signed [C-1:0] qy);
        logic r;
        if (x0 != x1) begin
            r = (x0 <= qx && qx <= x1) || (x0 >= qx && qx >= x1);
        end else begin
            r = (y0 <= qy && qy <= y1) || (y0 >= qy && qy >= y1);
        end
        return r;
    endfunction

    function automatic logic signed [OUT_W-1:0] to_fix(input logic signed [C-1:0] c);
        logic signed [FW-1:0] v;
        logic signed [FW-1:0] r;
        v = FW'(c) <<< FRAC_BITS;
        if (v > FIX_MAX) begin
            r = FIX_MAX;
        end else if (v < FIX_MIN) begin
            r = FIX_MIN;
        end else begin
            r = v;
        end
        return r[OUT_W-1:0];
    endfunction

    function automatic logic strict_in(input logic signed [SW-1:0] n,
                                       input logic signed [SW-1:0] d);
        return (d > 0) ? (n > 0 && n < d) : (n < 0 && n > d);
    endfunction

    function automatic logic outside(input logic signed [SW-1:0] n,
                                     input logic signed [SW-1:0] d);
        return (d > 0) ? (n < 0 || n > d) : (n > 0 || n < d);
    endfunction

    logic en;
    logic     m_valid_reg;
    ssi_out_t m_data_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // stage 1: cross-product terms
    logic signed [DIFF_W-1:0] e_abx, e_dcy, e_dcx, e_bay, e_acx, e_acy, e_bax, e_cay, e_cax;
    logic signed [PW-1:0] p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg;
    ssi_in_t c1_reg;
    logic    v1_reg;

    assign e_abx = DIFF_W'(s_data.ax) - DIFF_W'(s_data.bx);
    assign e_dcy = DIFF_W'(s_data.dy) - DIFF_W'(s_data.cy);
    assign e_dcx = DIFF_W'(s_data.dx) - DIFF_W'(s_data.cx);
    assign e_bay = DIFF_W'(s_data.by_coord) - DIFF_W'(s_data.ay);
    assign e_acx = DIFF_W'(s_data.ax) - DIFF_W'(s_data.cx);
    assign e_acy = DIFF_W'(s_data.ay) - DIFF_W'(s_data.cy);
    assign e_bax = DIFF_W'(s_data.bx) - DIFF_W'(s_data.ax);
    assign e_cay = DIFF_W'(s_data.cy) - DIFF_W'(s_data.ay);
    assign e_cax = DIFF_W'(s_data.cx) - DIFF_W'(s_data.ax);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg <= PW'(e_abx) * PW'(e_dcy);
            p2_reg <= PW'(e_dcx) * PW'(e_bay);
            p3_reg <= PW'(e_acx) * PW'(e_dcy);
            p4_reg <= PW'(e_dcx) * PW'(e_acy);
            p5_reg <= PW'(e_bax) * PW'(e_cay);
            p6_reg <= PW'(e_cax) * PW'(e_bay);
            c1_reg <= s_data;
        end
    end

    // stage 2: denominator, numerators, class, parallel-case point
    logic signed [SW-1:0] den, ns, nt, den_neg, ns_neg;
    logic [1:0]              cls_next;
    logic signed [OUT_W-1:0] ppx_next, ppy_next;
    ssi_side_t       side2_next, side2_reg;
    logic [MAGW-1:0] num2_reg, den2_reg;
    logic            v2_reg;

    assign den     = SW'(p1_reg) + SW'(p2_reg);
    assign ns      = SW'(p3_reg) - SW'(p4_reg);
    assign nt      = SW'(p5_reg) - SW'(p6_reg);
    assign den_neg = -den;
    assign ns_neg  = -ns;

    always_comb begin
        cls_next = CLS_NONE;
        ppx_next = '0;
        ppy_next = '0;
        if (den == '0) begin
            if (nt == '0) begin
                if (between(c1_reg.ax, c1_reg.ay, c1_reg.bx, c1_reg.by_coord,
                            c1_reg.cx, c1_reg.cy)) begin
                    cls_next = CLS_OVERLAP;
                    ppx_next = to_fix(c1_reg.cx);
                    ppy_next = to_fix(c1_reg.cy);
                end else if (between(c1_reg.ax, c1_reg.ay, c1_reg.bx, c1_reg.by_coord,
                                     c1_reg.dx, c1_reg.dy)) begin
                    cls_next = CLS_OVERLAP;
                    ppx_next = to_fix(c1_reg.dx);
                    ppy_next = to_fix(c1_reg.dy);
                end else if (between(c1_reg.cx, c1_reg.cy, c1_reg.dx, c1_reg.dy,
                                     c1_reg.ax, c1_reg.ay)) begin
                    cls_next = CLS_OVERLAP;
                    ppx_next = to_fix(c1_reg.ax);
                    ppy_next = to_fix(c1_reg.ay);
                end else if (between(c1_reg.cx, c1_reg.cy, c1_reg.dx, c1_reg.dy,
                                     c1_reg.bx, c1_reg.by_coord)) begin
                    cls_next = CLS_OVERLAP;
                    ppx_next = to_fix(c1_reg.bx);
                    ppy_next = to_fix(c1_reg.by_coord);
                end
            end
        end else begin
            if (ns == '0 || ns == den || nt == '0 || nt == den) begin
                cls_next = CLS_VERTEX;
            end
            if (strict_in(ns, den) && strict_in(nt, den)) begin
                cls_next = CLS_PROPER;
            end else if (outside(ns, den) || outside(nt, den)) begin
                cls_next = CLS_NONE;
            end
        end
    end

    always_comb begin
        side2_next.cls   = cls_next;
        side2_next.par   = (den == '0);
        side2_next.ppx   = ppx_next;
        side2_next.ppy   = ppy_next;
        side2_next.neg_s = (ns < 0) != (den < 0);
        side2_next.ax    = c1_reg.ax;
        side2_next.ay    = c1_reg.ay;
        side2_next.ex    = DIFF_W'(c1_reg.bx) - DIFF_W'(c1_reg.ax);
        side2_next.ey    = DIFF_W'(c1_reg.by_coord) - DIFF_W'(c1_reg.ay);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side2_reg <= side2_next;
            num2_reg  <= (ns < 0) ? ns_neg[MAGW-1:0] : ns[MAGW-1:0];
            den2_reg  <= (den < 0) ? den_neg[MAGW-1:0] : den[MAGW-1:0];
        end
    end

    // quotient |ns| * 2^F / |den|
    logic              vd;
    logic [QB-1:0]     quo;
    logic [SIDE_W-1:0] side_d;

    ssi_div #(
        .NUM_W     (MAGW),
        .DEN_W     (MAGW),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v2_reg),
        .in_num    (num2_reg),
        .in_den    (den2_reg),
        .in_side   (side2_reg),
        .out_valid (vd),
        .out_quo   (quo),
        .out_side  (side_d)
    );

    // stage 3: saturate quotient; beyond the cap the point clamps anyway
    logic [QX-1:0] qx_ext, qx_sat;
    logic [QC-1:0] q3_reg;
    ssi_side_t     side3_reg;
    logic          v3_reg;

    assign qx_ext = QX'(quo);
    assign qx_sat = (qx_ext > Q_CAP) ? Q_CAP : qx_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= vd;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q3_reg    <= qx_sat[QC-1:0];
            side3_reg <= side_d;
        end
    end

    // stage 4: split products q * |B - A|
    logic signed [DIFF_W-1:0] ex_neg, ey_neg;
    logic [DIFF_W-1:0]        ex_mag, ey_mag;
    logic [PLW-1:0] lox4_reg, loy4_reg;
    logic [PHW-1:0] hix4_reg, hiy4_reg;
    logic           negx4_reg, negy4_reg;
    ssi_side_t      side4_reg;
    logic           v4_reg;

    assign ex_neg = -side3_reg.ex;
    assign ey_neg = -side3_reg.ey;
    assign ex_mag = (side3_reg.ex < 0) ? ex_neg : side3_reg.ex;
    assign ey_mag = (side3_reg.ey < 0) ? ey_neg : side3_reg.ey;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lox4_reg  <= PLW'(q3_reg[QL-1:0]) * PLW'(ex_mag);
            hix4_reg  <= PHW'(q3_reg[QC-1:QL]) * PHW'(ex_mag);
            loy4_reg  <= PLW'(q3_reg[QL-1:0]) * PLW'(ey_mag);
            hiy4_reg  <= PHW'(q3_reg[QC-1:QL]) * PHW'(ey_mag);
            negx4_reg <= side3_reg.neg_s ^ (side3_reg.ex < 0);
            negy4_reg <= side3_reg.neg_s ^ (side3_reg.ey < 0);
            side4_reg <= side3_reg;
        end
    end

    // stage 5: recombine and apply sign
    logic [MGW-1:0]       magx, magy;
    logic signed [MW-1:0] smx, smy;
    logic signed [MW-1:0] prodx5_reg, prody5_reg;
    ssi_side_t            side5_reg;
    logic                 v5_reg;

    assign magx = MGW'(lox4_reg) + (MGW'(hix4_reg) << QL);
    assign magy = MGW'(loy4_reg) + (MGW'(hiy4_reg) << QL);
    assign smx  = $signed({1'b0, magx});
    assign smy  = $signed({1'b0, magy});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prodx5_reg <= negx4_reg ? -smx : smx;
            prody5_reg <= negy4_reg ? -smy : smy;
            side5_reg  <= side4_reg;
        end
    end

    // stage 6: add A, clamp, select, output register
    logic signed [RW-1:0] rx, ry;
    logic signed [RW-1:0] rxc, ryc;
    ssi_out_t             out_next;

    assign rx = RW'(prodx5_reg) + (RW'(side5_reg.ax) <<< FRAC_BITS);
    assign ry = RW'(prody5_reg) + (RW'(side5_reg.ay) <<< FRAC_BITS);

    always_comb begin
        rxc = (rx > RES_MAX) ? RES_MAX : ((rx < RES_MIN) ? RES_MIN : rx);
        ryc = (ry > RES_MAX) ? RES_MAX : ((ry < RES_MIN) ? RES_MIN : ry);
        out_next.hit_class = side5_reg.cls;
        if (side5_reg.par) begin
            out_next.px = side5_reg.ppx;
            out_next.py = side5_reg.ppy;
        end else begin
            out_next.px = rxc[OUT_W-1:0];
            out_next.py = ryc[OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // parallel pairs never classify as a crossing or vertex touch
    assert property (@(posedge aclk) disable iff (!aresetn)
        v5_reg && side5_reg.par |->
            side5_reg.cls == CLS_NONE || side5_reg.cls == CLS_OVERLAP)
        else $error("parallel pair with crossing class");

    // parallel miss gives the origin
    assert property (@(posedge aclk) disable iff (!aresetn)
        v5_reg && side5_reg.par && side5_reg.cls == CLS_NONE |->
            side5_reg.ppx == '0 && side5_reg.ppy == '0)
        else $error("parallel miss with nonzero point");

    // a stalled result blocks new transactions
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while output stalled");

    // a taken result is replaced by the next stage in the following cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> m_valid == $past(v5_reg))
        else $error("output valid lost or invented");

endmodule

FILE: rtl/ssi_div.sv
// ----------------------------------------------------------------------------
// ssi_div
// Pipelined restoring divider, one quotient bit per stage. Computes
// floor(num * 2^FRAC_BITS / den) on unsigned operands; sideband rides along.
// ----------------------------------------------------------------------------
module ssi_div
    import ssi_pkg::*;
#(
    parameter int NUM_W     = 2 * COORD_BITS + 2,
    parameter int DEN_W     = 2 * COORD_BITS + 2,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SIDE_W    = $bits(ssi_side_t)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [NUM_W-1:0]           in_num,
    input  logic [DEN_W-1:0]           in_den,
    input  logic [SIDE_W-1:0]          in_side,
    output logic                       out_valid,
    output logic [NUM_W+FRAC_BITS-1:0] out_quo,
    output logic [SIDE_W-1:0]          out_side
);

    localparam int QB = NUM_W + FRAC_BITS;

    logic [QB-1:0]     w_reg    [QB];
    logic [DEN_W-1:0]  rem_reg  [QB];
    logic [DEN_W-1:0]  den_reg  [QB];
    logic [SIDE_W-1:0] side_reg [QB];
    logic              vld_reg  [QB];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [QB-1:0]     w_in;
        logic [DEN_W-1:0]  rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [SIDE_W-1:0] side_in;
        logic              vld_in;
        logic [DEN_W:0]    trial;
        logic              take;
        logic [DEN_W:0]    diff;
        logic [QB-1:0]     w_next;
        logic [DEN_W-1:0]  rem_next;

        if (k == 0) begin : g_first
            assign w_in    = QB'(in_num) << FRAC_BITS;
            assign rem_in  = '0;
            assign den_in  = in_den;
            assign side_in = in_side;
            assign vld_in  = in_valid;
        end else begin : g_rest
            assign w_in    = w_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        assign trial    = {rem_in, w_in[QB-1]};
        assign take     = trial >= {1'b0, den_in};
        assign diff     = trial - {1'b0, den_in};
        assign rem_next = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        assign w_next   = {w_in[QB-2:0], take};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                w_reg[k]    <= w_next;
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[QB-1];
    assign out_quo   = w_reg[QB-1];
    assign out_side  = side_reg[QB-1];

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for segment_segment_intersect. A directed table of
// segment pairs is followed by mixed random pairs. Every result is checked
// field by field against a built-in predictor or a typed-in expectation.
// Each phase uses a different amount of source idling and sink back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
    import ssi_pkg::*;
();

    localparam int  WDOG_LIMIT = 5000;
    localparam int  DRAIN_CYC  = 80;
    localparam int  RAND_ITEMS = 132;
    localparam int  DIR_ROWS   = 23;
    localparam int  FB         = FRAC_BITS_DEF;
    localparam longint CAP     = longint'(1) <<< 62;

    typedef struct {
        ssi_in_t  seg;
        bit       typed;
        ssi_out_t res;
    } seg_txn_t;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    ssi_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    ssi_out_t m_data;

    seg_txn_t seg_q[$];
    ssi_out_t hit_q[$];
    seg_txn_t dir_tab[DIR_ROWS];
    int       src_idle = 0;
    int       snk_stall = 0;
    int       err_cnt = 0;
    int       quiet_cyc = 0;

    always #5 aclk = ~aclk;

    segment_segment_intersect u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint mul_cap(longint a, longint b);
        longint ua, ub, m;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        if (ub != 0 && ua > CAP / ub) m = CAP;
        else m = ua * ub;
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function automatic bit on_span(longint x0, longint y0, longint x1, longint y1,
                                   longint qx, longint qy);
        if (x0 != x1) return (x0 <= qx && qx <= x1) || (x0 >= qx && qx >= x1);
        return (y0 <= qy && qy <= y1) || (y0 >= qy && qy >= y1);
    endfunction

    function automatic bit strictly_in(longint n, longint d);
        return d > 0 ? (n > 0 && n < d) : (n < 0 && n > d);
    endfunction

    function automatic bit beyond(longint n, longint d);
        return d > 0 ? (n < 0 || n > d) : (n > 0 || n < d);
    endfunction

    function automatic ssi_out_t predict_hit(ssi_in_t p);
        longint ax, ay, bx, by, cx, cy, dx, dy;
        longint den, area, ns, nt, q, s, rx, ry;
        logic [1:0] cls;
        ssi_out_t r;
        ax = p.ax; ay = p.ay; bx = p.bx; by = p.by_coord;
        cx = p.cx; cy = p.cy; dx = p.dx; dy = p.dy;
        rx = 0; ry = 0; cls = CLS_NONE;
        den = ax * (dy - cy) + bx * (cy - dy) + dx * (by - ay) + cx * (ay - by);
        if (den == 0) begin
            area = (bx - ax) * (cy - ay) - (cx - ax) * (by - ay);
            if (area == 0) begin
                if (on_span(ax, ay, bx, by, cx, cy)) begin
                    cls = CLS_OVERLAP; rx = clamp32(cx <<< FB); ry = clamp32(cy <<< FB);
                end else if (on_span(ax, ay, bx, by, dx, dy)) begin
                    cls = CLS_OVERLAP; rx = clamp32(dx <<< FB); ry = clamp32(dy <<< FB);
                end else if (on_span(cx, cy, dx, dy, ax, ay)) begin
                    cls = CLS_OVERLAP; rx = clamp32(ax <<< FB); ry = clamp32(ay <<< FB);
                end else if (on_span(cx, cy, dx, dy, bx, by)) begin
                    cls = CLS_OVERLAP; rx = clamp32(bx <<< FB); ry = clamp32(by <<< FB);
                end
            end
        end else begin
            ns = ax * (dy - cy) + cx * (ay - dy) + dx * (cy - ay);
            nt = -(ax * (cy - by) + bx * (ay - cy) + cx * (by - ay));
            if (ns == 0 || ns == den || nt == 0 || nt == den) cls = CLS_VERTEX;
            if (strictly_in(ns, den) && strictly_in(nt, den)) cls = CLS_PROPER;
            else if (beyond(ns, den) || beyond(nt, den)) cls = CLS_NONE;
            q = (((ns < 0) ? -ns : ns) <<< FB) / ((den < 0) ? -den : den);
            if (q > CAP) q = CAP;
            s = ((ns < 0) != (den < 0)) ? -q : q;
            rx = clamp32((ax <<< FB) + mul_cap(s, bx - ax));
            ry = clamp32((ay <<< FB) + mul_cap(s, by - ay));
        end
        r.hit_class = cls;
        r.px = rx[31:0];
        r.py = ry[31:0];
        return r;
    endfunction

    function automatic ssi_in_t mk_seg(int a0, int a1, int b0, int b1,
                                       int c0, int c1, int d0, int d1);
        ssi_in_t p;
        p.ax = a0[15:0]; p.ay = a1[15:0]; p.bx = b0[15:0]; p.by_coord = b1[15:0];
        p.cx = c0[15:0]; p.cy = c1[15:0]; p.dx = d0[15:0]; p.dy = d1[15:0];
        return p;
    endfunction

    function automatic ssi_out_t mk_res(logic [1:0] c, int x, int y);
        ssi_out_t r;
        r.hit_class = c; r.px = x; r.py = y;
        return r;
    endfunction

    function automatic int rnd_in(int lo, int hi);
        return int'($urandom_range(hi - lo)) + lo;
    endfunction

    function automatic int rnd_edge();
        case ($urandom_range(5))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            4: return 1;
            default: return rnd_in(-32768, 32767);
        endcase
    endfunction

    function automatic ssi_in_t rnd_seg();
        ssi_in_t p;
        int x0, y0, ux, uy;
        case ($urandom_range(9))
            0, 1, 2: p = ssi_in_t'({$urandom, $urandom, $urandom, $urandom});
            3, 4, 5: p = mk_seg(rnd_in(-6, 6), rnd_in(-6, 6), rnd_in(-6, 6), rnd_in(-6, 6),
                                rnd_in(-6, 6), rnd_in(-6, 6), rnd_in(-6, 6), rnd_in(-6, 6));
            6, 7: begin
                x0 = rnd_in(-1000, 1000); y0 = rnd_in(-1000, 1000);
                ux = rnd_in(-4, 4); uy = rnd_in(-4, 4);
                p = mk_seg(x0 + ux * rnd_in(-5, 5), y0 + uy * rnd_in(-5, 5),
                           x0 + ux * rnd_in(-5, 5), y0 + uy * rnd_in(-5, 5),
                           x0, y0, x0 + ux * rnd_in(-5, 5), y0 + uy * rnd_in(-5, 5));
                p.ay = p.ay - p.ax + p.ax;
                p = mk_seg(p.ax, y0 + (int'(p.ax) - x0) / (ux == 0 ? 1 : 1) * 0 + uy * 0
                           + ((ux == 0) ? rnd_in(-5, 5) * uy : (int'(p.ax) - x0) / ux * uy),
                           p.bx, y0 + ((ux == 0) ? rnd_in(-5, 5) * uy
                                       : (int'(p.bx) - x0) / ux * uy),
                           p.cx, p.cy, p.dx, y0 + ((ux == 0) ? rnd_in(-5, 5) * uy
                                                   : (int'(p.dx) - x0) / ux * uy));
            end
            8: begin
                p = ssi_in_t'({$urandom, $urandom, $urandom, $urandom});
                if ($urandom_range(1)) begin
                    p.cx = p.ax; p.cy = p.ay;
                end else begin
                    p.dx = p.bx; p.dy = p.by_coord;
                end
            end
            default: p = mk_seg(rnd_edge(), rnd_edge(), rnd_edge(), rnd_edge(),
                                rnd_edge(), rnd_edge(), rnd_edge(), rnd_edge());
        endcase
        return p;
    endfunction

    task automatic add_seg(ssi_in_t p, bit typed = 1'b0, ssi_out_t r = '0);
        seg_txn_t t;
        t.seg = p; t.typed = typed; t.res = r;
        seg_q.push_back(t);
    endtask

    task automatic wait_idle();
        wait (seg_q.size() == 0 && !s_valid && hit_q.size() == 0);
        @(posedge aclk);
    endtask

    // source side
    always @(posedge aclk) begin
        seg_txn_t t;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (seg_q.size() != 0 && int'($urandom_range(99)) >= src_idle) begin
                t = seg_q.pop_front();
                s_valid <= 1'b1;
                s_data  <= t.seg;
                hit_q.push_back(t.typed ? t.res : predict_hit(t.seg));
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // sink side and checking
    always @(posedge aclk) begin
        ssi_out_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= (int'($urandom_range(99)) >= snk_stall);
            if (m_valid && m_ready) begin
                if (hit_q.size() == 0) begin
                    $display("%0t: unexpected transaction %h", $realtime, m_data);
                    err_cnt++;
                end else begin
                    e = hit_q.pop_front();
                    if (m_data.hit_class !== e.hit_class) begin
                        $display("%0t: hit_class exp %0d got %0d", $realtime,
                                 e.hit_class, m_data.hit_class);
                        err_cnt++;
                    end
                    if (m_data.px !== e.px) begin
                        $display("%0t: px exp %0d got %0d", $realtime, e.px, m_data.px);
                        err_cnt++;
                    end
                    if (m_data.py !== e.py) begin
                        $display("%0t: py exp %0d got %0d", $realtime, e.py, m_data.py);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cyc <= 0;
        else quiet_cyc <= quiet_cyc + 1;
        if (quiet_cyc >= WDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int idle_src[4];
        int idle_snk[4];
        idle_src = '{0, 60, 0, 26};
        idle_snk = '{0, 0, 60, 26};

        // directed table: segment pair, typed flag, typed result
        dir_tab = '{
            '{mk_seg(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_res(CLS_OVERLAP, 0, 0)},
            '{mk_seg(0, 0, 10, 0, 0, 1, 10, 1), 1'b1, mk_res(CLS_NONE, 0, 0)},
            '{mk_seg(0, 0, 2, 0, 1, -1, 1, 1), 1'b1, mk_res(CLS_PROPER, 65536, 0)},
            '{mk_seg(0, 0, 2, 0, 2, -1, 2, 1), 1'b1, mk_res(CLS_VERTEX, 131072, 0)},
            '{mk_seg(0, 0, 2, 0, 0, -1, 0, 1), 1'b1, mk_res(CLS_VERTEX, 0, 0)},
            '{mk_seg(0, 0, 10, 0, 5, 0, 20, 0), 1'b1, mk_res(CLS_OVERLAP, 327680, 0)},
            '{mk_seg(0, 0, 10, 0, 20, 0, 30, 0), 1'b1, mk_res(CLS_NONE, 0, 0)},
            '{mk_seg(5, 0, 6, 0, 0, 0, 10, 0), 1'b1, mk_res(CLS_OVERLAP, 327680, 0)},
            '{mk_seg(0, 0, 0, 10, 0, 12, 0, 3), 1'b1, mk_res(CLS_OVERLAP, 0, 196608)},
            '{mk_seg(3, 3, 3, 3, 3, 3, 3, 3), 1'b1,
              mk_res(CLS_OVERLAP, 196608, 196608)},
            '{mk_seg(1, 1, 1, 1, 2, 2, 2, 2), 1'b1, mk_res(CLS_NONE, 0, 0)},
            '{mk_seg(-32768, -32768, -32768, -32768, -32768, -32768, 0, 0), 1'b1,
              mk_res(CLS_OVERLAP, 32'sh8000_0000, 32'sh8000_0000)},
            '{mk_seg(32767, 32767, 32767, 0, 32767, 32767, 32767, 32767), 1'b1,
              mk_res(CLS_OVERLAP, 32'sh7fff_0000, 32'sh7fff_0000)},
            '{mk_seg(0, 0, 4, 0, 1, 1, 3, 5), 1'b0, '0},
            '{mk_seg(0, 0, 3, 0, 1, 1, 2, -2), 1'b0, '0},
            '{mk_seg(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768),
              1'b0, '0},
            '{mk_seg(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768),
              1'b0, '0},
            '{mk_seg(32766, 0, 32767, 1, -32768, 32767, -32767, 32767), 1'b0, '0},
            '{mk_seg(-32767, 0, -32768, 1, 32767, -32768, 32766, -32768), 1'b0, '0},
            '{mk_seg(0, 0, 1, 32767, -32768, -32768, 32767, -32767), 1'b0, '0},
            '{mk_seg(0, 0, 3, 1, 1, 0, 2, 1), 1'b0, '0},
            '{mk_seg(-1, -1, -1, -1, 0, 0, 1, 1), 1'b0, '0},
            '{mk_seg(0, 0, 7, 3, 7, 3, 9, -4), 1'b0, '0}
        };

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i]) add_seg(dir_tab[i].seg, dir_tab[i].typed, dir_tab[i].res);

        for (int ph = 0; ph < 4; ph++) begin
            src_idle  = idle_src[ph];
            snk_stall = idle_snk[ph];
            for (int i = 0; i < RAND_ITEMS; i++) add_seg(rnd_seg());
            wait_idle();
        end

        repeat (DRAIN_CYC) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
